// File: rtl/core/srrw_pkg.sv
// ----------------------------------------------------------------------------
// Selective-repeat receive window: shared package
// Types, widths and constants for the receive window front, back and top.
// ----------------------------------------------------------------------------
package srrw_pkg;

  // Default configuration of the window.
  localparam int unsigned WindowDef      = 8;
  localparam int unsigned PacketBytesDef = 256;
  localparam int unsigned BufferBytesDef = 1048576;

  // Fixed field widths.
  localparam int unsigned LenW      = 9;
  localparam int unsigned OffOutW   = 20;
  localparam int unsigned TotalW    = 21;
  localparam int unsigned AckW      = 8;
  localparam int unsigned CountW    = 4;
  localparam int unsigned SlotsMax  = 8;
  localparam int unsigned SlotIdxW  = 3;

  // Depth of the queue between front and back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Acknowledgement byte sent once all data has arrived.
  localparam logic [AckW-1:0] AllDoneCode = 8'd50;

  typedef struct packed {
    logic [LenW-1:0] packet_length;
    logic            is_final;
    logic            damaged;
  } in_item_t;

  typedef struct packed {
    logic               write_valid;
    logic [OffOutW-1:0] write_offset;
    logic               ack_send;
    logic [AckW-1:0]    ack_byte;
    logic               finished;
    logic [TotalW-1:0]  received_bytes;
    logic               offset_overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StFill = 3'b010,
    StCopy = 3'b100
  } back_state_e;

endpackage

// File: rtl/core/selective_repeat_receive_window_top.sv
// ----------------------------------------------------------------------------
// Selective-repeat receive window: top level
// Receiver side of a windowed selective-repeat scheme: buffer offsets for
// good packets, damage acknowledgements at each window end.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+-------------------------
//  in       | input     | in_valid_i / in_stall_o   | in_item_i  (in_item_t)
//  out      | output    | out_valid_o / out_stall_i | out_item_o (out_item_t)
//
// A packet is registered in the front queue and then in the back's output
// register; ordinary packets flow at one per cycle while the back is idle and
// the output does not stall. At a window end the back writes the fresh offsets
// (up to WINDOW) in its fill state, sees that the fill is complete, and then
// loads the new offset table in its copy state. Reset is asynchronous, active
// low, and restores the initial window at once. A stalled output holds its
// result while the two-entry queue keeps taking packets until it is full.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window_top import srrw_pkg::*; #(
  parameter int unsigned WINDOW       = WindowDef,
  parameter int unsigned PACKET_BYTES = PacketBytesDef,
  parameter int unsigned BUFFER_BYTES = BufferBytesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic     cmd_valid;
  in_item_t cmd;
  logic     cmd_pop;

  srrw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  srrw_back #(
    .WINDOW       (WINDOW),
    .PACKET_BYTES (PACKET_BYTES),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: rtl/core/srrw_front.sv
// ----------------------------------------------------------------------------
// Selective-repeat receive window: front
// Accepts packet descriptors and holds them in a short queue for the back.
// ----------------------------------------------------------------------------
module srrw_front import srrw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     cmd_valid_o,
  output in_item_t cmd_o,
  input  logic     cmd_pop_i
);

  in_item_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]   count_q, count_d;
  logic                   push;
  logic                   pop;

  assign in_stall_o  = (count_q == QueueCntW'(QueueDepth));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

// File: rtl/core/srrw_back.sv
// ----------------------------------------------------------------------------
// Selective-repeat receive window: back
// Processes one packet per step, keeps the window state and rebuilds the
// offset table at the end of each window, one fresh offset per cycle.
// ----------------------------------------------------------------------------
module srrw_back import srrw_pkg::*; #(
  parameter int unsigned WINDOW       = WindowDef,
  parameter int unsigned PACKET_BYTES = PacketBytesDef,
  parameter int unsigned BUFFER_BYTES = BufferBytesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  in_item_t  cmd_i,
  output logic      cmd_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  // Offsets must also hold the initial table, which may pass the buffer end.
  localparam int unsigned OffMax = (BUFFER_BYTES > (SlotsMax - 1) * PACKET_BYTES) ?
                                   BUFFER_BYTES : (SlotsMax - 1) * PACKET_BYTES;
  localparam int unsigned OffW   = $clog2(OffMax + 1);
  localparam int unsigned SumW   = OffW + 1;

  back_state_e         state_q, state_d;
  logic [OffW-1:0]     win_off_q [SlotsMax];
  logic [OffW-1:0]     win_off_d [SlotsMax];
  logic [OffW-1:0]     nxt_off_q [SlotsMax];
  logic                nxt_we;
  logic [SlotIdxW-1:0] nxt_waddr;
  logic [OffW-1:0]     nxt_wdata;
  logic [CountW-1:0]   next_fill_q, next_fill_d;
  logic [CountW-1:0]   slot_q, slot_d;
  logic [CountW-1:0]   limit_q, limit_d;
  logic [CountW-1:0]   dmg_cnt_q, dmg_cnt_d;
  logic [AckW-1:0]     ack_mask_q, ack_mask_d;
  logic                final_seen_q, final_seen_d;
  logic                done_q, done_d;
  logic [TotalW-1:0]   total_q, total_d;
  logic [OffW-1:0]     fill_acc_q, fill_acc_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  logic                step;
  logic [OffW-1:0]     off;
  logic [SumW-1:0]     end_sum;
  logic                ovf;
  logic                wr;
  logic [CountW-1:0]   limit_a;
  logic [AckW-1:0]     mask_a;
  logic [CountW-1:0]   fill_a;
  logic [CountW-1:0]   dmg_a;
  logic                final_a;
  logic [TotalW-1:0]   total_a;
  logic [CountW-1:0]   slot_inc;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

  // Next fresh offset, held at the buffer end once it gets there.
  function automatic logic [OffW-1:0] fresh_next(input logic [OffW-1:0] v);
    logic [SumW-1:0] s;
    s = SumW'(v) + SumW'(PACKET_BYTES);
    fresh_next = (s > SumW'(BUFFER_BYTES)) ? OffW'(BUFFER_BYTES) : OffW'(s);
  endfunction

  // A step needs a free output register, or one that is emptied this cycle.
  assign step        = (state_q == StIdle) && cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign cmd_pop_o   = step;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign off      = win_off_q[slot_q[SlotIdxW-1:0]];
  assign end_sum  = SumW'(off) + SumW'(cmd_i.packet_length);
  assign ovf      = end_sum > SumW'(BUFFER_BYTES);
  assign wr       = !cmd_i.damaged && !ovf;
  assign slot_inc = slot_q + 1'b1;
  assign limit_a  = cmd_i.is_final ? slot_inc : limit_q;
  assign fill_a   = cmd_i.damaged ? sat_inc(next_fill_q) : next_fill_q;
  assign dmg_a    = cmd_i.damaged ? sat_inc(dmg_cnt_q) : dmg_cnt_q;
  assign final_a  = final_seen_q || (wr && cmd_i.is_final);
  assign total_a  = (wr && cmd_i.is_final) ? TotalW'(end_sum) : total_q;

  always_comb begin
    mask_a = ack_mask_q;
    // Slots past the window set no bit; the first slot sits in bit WINDOW-1.
    if (cmd_i.damaged && (32'(slot_q) < WINDOW)) begin
      mask_a = ack_mask_q |
               (AckW'(1) << (SlotIdxW'(WINDOW - 1) - slot_q[SlotIdxW-1:0]));
    end
  end

  always_comb begin
    state_d      = state_q;
    win_off_d    = win_off_q;
    next_fill_d  = next_fill_q;
    slot_d       = slot_q;
    limit_d      = limit_q;
    dmg_cnt_d    = dmg_cnt_q;
    ack_mask_d   = ack_mask_q;
    final_seen_d = final_seen_q;
    done_d       = done_q;
    total_d      = total_q;
    fill_acc_d   = fill_acc_q;
    nxt_we       = 1'b0;
    nxt_waddr    = next_fill_q[SlotIdxW-1:0];
    nxt_wdata    = off;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;

    case (state_q)
      StIdle: begin
        if (step) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          if (done_q) begin
            out_d.finished       = 1'b1;
            out_d.received_bytes = total_q;
          end else begin
            out_d.write_valid     = wr;
            out_d.write_offset    = OffOutW'(off);
            out_d.offset_overflow = ovf;
            nxt_we       = cmd_i.damaged && (32'(next_fill_q) < WINDOW);
            limit_d      = limit_a;
            ack_mask_d   = mask_a;
            next_fill_d  = fill_a;
            dmg_cnt_d    = dmg_a;
            final_seen_d = final_a;
            total_d      = total_a;
            if (final_a && (mask_a == '0)) begin
              done_d          = 1'b1;
              out_d.ack_send  = 1'b1;
              out_d.ack_byte  = AllDoneCode;
              out_d.finished  = 1'b1;
            end else begin
              slot_d = slot_inc;
              if (slot_inc == limit_a) begin
                // End of window: send the mask and start rebuilding the table.
                out_d.ack_send = 1'b1;
                out_d.ack_byte = mask_a;
                ack_mask_d     = '0;
                slot_d         = '0;
                dmg_cnt_d      = '0;
                if (final_a) begin
                  limit_d = dmg_a;
                end
                fill_acc_d = fresh_next(off);
                state_d    = StFill;
              end
            end
            out_d.received_bytes = total_a;
          end
        end
      end
      StFill: begin
        // Fresh offsets follow the retransmissions until the window is full or a final packet was seen.
        if ((32'(next_fill_q) < WINDOW) && !final_seen_q) begin
          nxt_we      = 1'b1;
          nxt_wdata   = fill_acc_q;
          next_fill_d = next_fill_q + 1'b1;
          fill_acc_d  = fresh_next(fill_acc_q);
        end else begin
          state_d = StCopy;
        end
      end
      StCopy: begin
        for (int k = 0; k < SlotsMax; k++) begin
          if (k < WINDOW) begin
            win_off_d[k] = nxt_off_q[k];
          end
        end
        next_fill_d = '0;
        state_d     = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      for (int i = 0; i < SlotsMax; i++) begin
        win_off_q[i] <= OffW'(i * PACKET_BYTES);
      end
      next_fill_q  <= '0;
      slot_q       <= '0;
      limit_q      <= CountW'(WINDOW);
      dmg_cnt_q    <= '0;
      ack_mask_q   <= '0;
      final_seen_q <= 1'b0;
      done_q       <= 1'b0;
      total_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      win_off_q    <= win_off_d;
      next_fill_q  <= next_fill_d;
      slot_q       <= slot_d;
      limit_q      <= limit_d;
      dmg_cnt_q    <= dmg_cnt_d;
      ack_mask_q   <= ack_mask_d;
      final_seen_q <= final_seen_d;
      done_q       <= done_d;
      total_q      <= total_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fill_acc_q <= fill_acc_d;
    out_q      <= out_d;
    if (nxt_we) begin
      nxt_off_q[nxt_waddr] <= nxt_wdata;
    end
  end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Selective-repeat receive window: testbench
// Drives packet descriptors into the receive window and checks every result
// against the directed table or, for the rest, a behavioural predictor held in
// the bench. A short table of directed packets comes first. Random traffic
// follows, then a long stretch of mostly good packets that pushes the offsets
// towards the end of the buffer, then retransmissions at the buffer boundary,
// a final packet, the all-done acknowledgement and packets to the finished block.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import srrw_pkg::*;

  localparam int unsigned SlotWrap    = 1 << CountW;
  localparam int unsigned LastSlotOff = BufferBytesDef - PacketBytesDef;
  localparam int unsigned RunUpEnd    = BufferBytesDef - SlotsMax * PacketBytesDef;

  typedef struct packed {
    in_item_t  pkt;
    logic      typed;
    out_item_t res;
  } packet_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  // Idle rates in percent, set by the stimulus for each traffic phase.
  int unsigned sender_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_receiver;
  int unsigned mismatch_count;

  out_item_t pending_slot_results [$];

  // Predicted state of the receive window.
  int unsigned       rx_win_off  [SlotsMax];
  int unsigned       rx_next_off [SlotsMax];
  int unsigned       rx_fill;
  int unsigned       rx_slot;
  int unsigned       rx_limit;
  int unsigned       rx_dmg;
  logic [AckW-1:0]   rx_mask;
  bit                rx_final;
  bit                rx_done;
  int unsigned       rx_total;

  // The first window has its results written out; the second is all damaged
  // and the third, made of the retransmissions, is all good.
  packet_row_t directed_rows [24] = '{
    '{'{9'd256, 1'b0, 1'b0}, 1'b1, '{1'b1, 20'd0,    1'b0, 8'h00, 1'b0, 21'd0, 1'b0}},
    '{'{9'd1,   1'b0, 1'b1}, 1'b1, '{1'b0, 20'd256,  1'b0, 8'h00, 1'b0, 21'd0, 1'b0}},
    '{'{9'd255, 1'b0, 1'b0}, 1'b1, '{1'b1, 20'd512,  1'b0, 8'h00, 1'b0, 21'd0, 1'b0}},
    '{'{9'd128, 1'b0, 1'b0}, 1'b1, '{1'b1, 20'd768,  1'b0, 8'h00, 1'b0, 21'd0, 1'b0}},
    '{'{9'd2,   1'b0, 1'b0}, 1'b1, '{1'b1, 20'd1024, 1'b0, 8'h00, 1'b0, 21'd0, 1'b0}},
    '{'{9'd17,  1'b0, 1'b0}, 1'b1, '{1'b1, 20'd1280, 1'b0, 8'h00, 1'b0, 21'd0, 1'b0}},
    '{'{9'd200, 1'b0, 1'b1}, 1'b1, '{1'b0, 20'd1536, 1'b0, 8'h00, 1'b0, 21'd0, 1'b0}},
    '{'{9'd256, 1'b0, 1'b0}, 1'b1, '{1'b1, 20'd1792, 1'b1, 8'h42, 1'b0, 21'd0, 1'b0}},
    '{'{9'd256, 1'b0, 1'b1}, 1'b0, '0},
    '{'{9'd1,   1'b0, 1'b1}, 1'b0, '0},
    '{'{9'd100, 1'b0, 1'b1}, 1'b0, '0},
    '{'{9'd64,  1'b0, 1'b1}, 1'b0, '0},
    '{'{9'd3,   1'b0, 1'b1}, 1'b0, '0},
    '{'{9'd255, 1'b0, 1'b1}, 1'b0, '0},
    '{'{9'd128, 1'b0, 1'b1}, 1'b0, '0},
    '{'{9'd9,   1'b0, 1'b1}, 1'b0, '0},
    '{'{9'd256, 1'b0, 1'b0}, 1'b0, '0},
    '{'{9'd1,   1'b0, 1'b0}, 1'b0, '0},
    '{'{9'd170, 1'b0, 1'b0}, 1'b0, '0},
    '{'{9'd85,  1'b0, 1'b0}, 1'b0, '0},
    '{'{9'd256, 1'b0, 1'b0}, 1'b0, '0},
    '{'{9'd1,   1'b0, 1'b0}, 1'b0, '0},
    '{'{9'd31,  1'b0, 1'b0}, 1'b0, '0},
    '{'{9'd240, 1'b0, 1'b0}, 1'b0, '0}
  };

  selective_repeat_receive_window_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out the result of one accepted packet and moves the window on.
  function automatic out_item_t advance_window(in_item_t pkt);
    out_item_t   res;
    int unsigned idx;
    int unsigned off;
    int unsigned fresh;
    bit          ovf;
    res = '0;
    if (rx_done) begin
      res.finished       = 1'b1;
      res.received_bytes = rx_total[TotalW-1:0];
      return res;
    end
    idx = rx_slot;
    off = rx_win_off[idx % SlotsMax];
    ovf = (off + pkt.packet_length) > BufferBytesDef;
    // A final packet closes the window at its own slot, damaged or not.
    if (pkt.is_final) rx_limit = (idx + 1) % SlotWrap;
    if (pkt.damaged) begin
      if (idx < WindowDef) rx_mask[WindowDef - idx - 1] = 1'b1;
      if (rx_fill < WindowDef) rx_next_off[rx_fill % SlotsMax] = off;
      if (rx_fill < SlotWrap - 1) rx_fill++;
      if (rx_dmg < SlotWrap - 1) rx_dmg++;
    end else if (!ovf) begin
      res.write_valid = 1'b1;
      if (pkt.is_final) begin
        rx_total = off + pkt.packet_length;
        rx_final = 1'b1;
      end
    end
    if (rx_final && rx_mask == '0) begin
      rx_done      = 1'b1;
      res.ack_send = 1'b1;
      res.ack_byte = AllDoneCode;
    end else begin
      rx_slot = (idx + 1) % SlotWrap;
      if (rx_slot == rx_limit) begin
        res.ack_send = 1'b1;
        res.ack_byte = rx_mask;
        // Fresh offsets follow on from the closing slot and stop at the buffer end.
        fresh = off;
        while (rx_fill < WindowDef && !rx_final) begin
          fresh = fresh + PacketBytesDef;
          if (fresh > BufferBytesDef) fresh = BufferBytesDef;
          rx_next_off[rx_fill % SlotsMax] = fresh;
          rx_fill++;
        end
        rx_mask = '0;
        rx_slot = 0;
        rx_fill = 0;
        if (rx_final) rx_limit = rx_dmg % SlotWrap;
        rx_dmg = 0;
        for (int k = 0; k < SlotsMax; k++) rx_win_off[k] = rx_next_off[k];
      end
    end
    res.write_offset    = off[OffOutW-1:0];
    res.finished        = rx_done;
    res.received_bytes  = rx_total[TotalW-1:0];
    res.offset_overflow = ovf;
    return res;
  endfunction

  function automatic in_item_t random_packet(int unsigned dmg_pct);
    in_item_t    pkt;
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) pkt.packet_length = 9'd1;
    else if (pick == 1) pkt.packet_length = 9'(PacketBytesDef);
    else pkt.packet_length = 9'($urandom_range(PacketBytesDef, 1));
    pkt.is_final = 1'b0;
    pkt.damaged  = ($urandom_range(99) < dmg_pct);
    return pkt;
  endfunction

  // Offers one packet, waits for the transaction and records its result.
  task automatic offer_packet(input in_item_t pkt, input logic typed, input out_item_t res);
    out_item_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= pkt;
    do @(posedge clk); while (in_stall);
    predicted = advance_window(pkt);
    pending_slot_results.push_back(typed ? res : predicted);
  endtask

  function automatic void check_field(string name, logic [TotalW-1:0] want,
                                      logic [TotalW-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  initial begin : result_check
    out_item_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_slot_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with none expected, got %h", $time, out_item);
        end else begin
          want = pending_slot_results.pop_front();
          check_field("write_valid", want.write_valid, out_item.write_valid);
          check_field("write_offset", want.write_offset, out_item.write_offset);
          check_field("ack_send", want.ack_send, out_item.ack_send);
          check_field("ack_byte", want.ack_byte, out_item.ack_byte);
          check_field("finished", want.finished, out_item.finished);
          check_field("received_bytes", want.received_bytes, out_item.received_bytes);
          check_field("offset_overflow", want.offset_overflow, out_item.offset_overflow);
        end
      end
    end
  end

  initial begin : receiver
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_receiver) begin
        // Long hold-off so that the queue fills and the input stalls.
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_receiver = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin : stimulus
    in_item_t    pkt;
    int unsigned n;
    int unsigned visits;
    sender_idle_pct = 35;
    recv_idle_pct   = 70;
    hold_receiver   = 1'b0;
    mismatch_count  = 0;
    for (int k = 0; k < SlotsMax; k++) begin
      rx_win_off[k]  = k * PacketBytesDef;
      rx_next_off[k] = 0;
    end
    rx_fill  = 0;
    rx_slot  = 0;
    rx_limit = WindowDef % SlotWrap;
    rx_dmg   = 0;
    rx_mask  = '0;
    rx_final = 1'b0;
    rx_done  = 1'b0;
    rx_total = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      offer_packet(directed_rows[i].pkt, directed_rows[i].typed, directed_rows[i].res);

    // Mixed traffic, no final packet so that the window keeps its full size.
    for (n = 0; n < 2000; n++) begin
      if (n == 1000) begin
        sender_idle_pct = 70;
        recv_idle_pct   = 35;
      end
      if (n == 500) hold_receiver = 1'b1;
      if (n == 1500) begin
        in_valid <= 1'b0;
        while (pending_slot_results.size() != 0) @(posedge clk);
      end
      offer_packet(random_packet(25), 1'b0, '0);
    end

    // Mostly good packets carry the offsets up towards the buffer end.
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    n = 0;
    while (rx_win_off[rx_slot % SlotsMax] < RunUpEnd && n < 8000) begin
      offer_packet(random_packet(10), 1'b0, '0);
      n++;
    end

    // At the buffer boundary: the last slot that still fits is damaged three
    // times, the second time as a damaged final packet, then resent intact as
    // the final packet. Slots past it sit at the buffer end and overflow.
    visits = 0;
    n = 0;
    while (!rx_done && n < 600) begin
      pkt = random_packet(30);
      if (rx_win_off[rx_slot % SlotsMax] == LastSlotOff) begin
        visits++;
        pkt.packet_length = 9'(PacketBytesDef);
        pkt.damaged       = (visits < 4);
        pkt.is_final      = (visits == 2 || visits >= 4);
      end
      offer_packet(pkt, 1'b0, '0);
      n++;
    end

    // Once finished the block ignores its input.
    sender_idle_pct = 35;
    recv_idle_pct   = 35;
    for (n = 0; n < 20; n++) begin
      pkt = random_packet(50);
      pkt.is_final = 1'($urandom_range(1));
      offer_packet(pkt, 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_slot_results.size() != 0) @(posedge clk);
    repeat (4 * (WindowDef + 2)) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
